// File: rtl/fca_pkg.sv
// Shared types and constants for the FAT cluster chain addresser.
package fca_pkg;

    localparam logic [15:0] FAT12_END  = 16'h0FF8;
    localparam logic [15:0] FAT16_END  = 16'hFFF8;
    localparam logic [15:0] FAT12_MASK = 16'h0FFF;
    localparam logic [15:0] ODD_BIT    = 16'h0001;

    localparam logic [3:0] SHIFT_MIN = 4'd9;
    localparam logic [3:0] SHIFT_MAX = 4'd12;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FAT_TYPE        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_START = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_COUNT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_COPIES    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SECTORS = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_LOG2     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENTRIES    = 4'd7;

    localparam logic        RST_FAT_TYPE        = 1'b0;
    localparam logic [31:0] RST_PARTITION_START = 32'd0;
    localparam logic [15:0] RST_RESERVED_COUNT  = 16'd1;
    localparam logic [2:0]  RST_TABLE_COPIES    = 3'd2;
    localparam logic [15:0] RST_TABLE_LENGTH    = 16'd9;
    localparam logic [7:0]  RST_CLUSTER_SECTORS = 8'd1;
    localparam logic [3:0]  RST_SECTOR_LOG2     = 4'd9;
    localparam logic [15:0] RST_ROOT_ENTRIES    = 16'd224;

    // cycles for the derived geometry to catch up after a register write
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef struct packed {
        logic        fat16;
        logic [31:0] first_table;
        logic [31:0] data_base;   // root + root_len - 2 * cluster_sectors
        logic [1:0]  shift_sel;   // sector size log2 minus 9, clamped
        logic [7:0]  cluster_sectors;
    } geom_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] start_cluster;
        logic [15:0] table_word;
    } item_t;

    typedef struct packed {
        logic [15:0] cluster;
        logic [31:0] prev_sector;
        logic        last_valid;
    } walk_state_t;

    typedef struct packed {
        logic [15:0] cluster_now;
        logic        chain_end;
        logic [31:0] table_sector;
        logic [11:0] entry_offset;
        logic [31:0] data_sector;
        logic        reload_table;
    } result_t;

endpackage

// File: rtl/fca_cfg.sv
// Configuration registers and the volume geometry derived from them.
module fca_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output fca_pkg::geom_t                geom,
    output logic                          busy
);
    import fca_pkg::*;

    logic        fat_type_reg;
    logic [31:0] part_start_reg;
    logic [15:0] rsvd_reg;
    logic [2:0]  copies_reg;
    logic [15:0] tlen_reg;
    logic [7:0]  csec_reg;
    logic [3:0]  ssl_reg;
    logic [15:0] rec_reg;

    logic [31:0] first_table_reg;
    logic [31:0] root_part_reg;
    logic [1:0]  sel_reg;
    logic [31:0] data_base_reg;
    logic [1:0]  settle_reg;
    logic [1:0]  settle_next;

    logic [1:0]  sel_next;
    logic [18:0] fat_area;
    logic [11:0] root_len;
    logic [31:0] root_part_next;

    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_type_reg   <= RST_FAT_TYPE;
            part_start_reg <= RST_PARTITION_START;
            rsvd_reg       <= RST_RESERVED_COUNT;
            copies_reg     <= RST_TABLE_COPIES;
            tlen_reg       <= RST_TABLE_LENGTH;
            csec_reg       <= RST_CLUSTER_SECTORS;
            ssl_reg        <= RST_SECTOR_LOG2;
            rec_reg        <= RST_ROOT_ENTRIES;
        end else if (wr) begin
            case (cfg_index)
                REG_FAT_TYPE:        fat_type_reg   <= cfg_data[0];
                REG_PARTITION_START: part_start_reg <= cfg_data;
                REG_RESERVED_COUNT:  rsvd_reg       <= cfg_data[15:0];
                REG_TABLE_COPIES:    copies_reg     <= cfg_data[2:0];
                REG_TABLE_LENGTH:    tlen_reg       <= cfg_data[15:0];
                REG_CLUSTER_SECTORS: csec_reg       <= cfg_data[7:0];
                REG_SECTOR_LOG2:     ssl_reg        <= cfg_data[3:0];
                REG_ROOT_ENTRIES:    rec_reg        <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (ssl_reg < SHIFT_MIN) begin
            sel_next = 2'd0;
        end else if (ssl_reg > SHIFT_MAX) begin
            sel_next = 2'd3;
        end else begin
            sel_next = 2'(ssl_reg - SHIFT_MIN);
        end
        fat_area = 19'(copies_reg) * 19'(tlen_reg);
        // 32-byte entries: (entries * 32) >> log2 == entries >> (log2 - 5)
        root_len = 12'(rec_reg >> (4'd4 + 4'(sel_next)));
        root_part_next = 32'(fat_area) + 32'(root_len) - 32'({csec_reg, 1'b0});
    end

    // two register steps keep the sums short; geometry is free-running
    always_ff @(posedge aclk) begin
        first_table_reg <= part_start_reg + 32'(rsvd_reg);
        root_part_reg   <= root_part_next;
        sel_reg         <= sel_next;
        data_base_reg   <= first_table_reg + root_part_reg;
    end

    always_comb begin
        if (wr) begin
            settle_next = SETTLE_CYCLES;
        end else if (settle_reg != 2'd0) begin
            settle_next = settle_reg - 2'd1;
        end else begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else begin
            settle_reg <= settle_next;
        end
    end

    assign busy = (settle_reg != 2'd0);

    always_comb begin
        geom.fat16           = fat_type_reg;
        geom.first_table     = first_table_reg;
        geom.data_base       = data_base_reg;
        geom.shift_sel       = sel_reg;
        geom.cluster_sectors = csec_reg;
    end

endmodule

// File: rtl/fca_step.sv
// One chain link: decode the next cluster and address its table entry and data.
module fca_step (
    input  fca_pkg::geom_t       geom,
    input  fca_pkg::item_t       item,
    input  fca_pkg::walk_state_t state,
    output fca_pkg::result_t     res,
    output fca_pkg::walk_state_t state_next
);
    import fca_pkg::*;

    logic [15:0] c;
    logic        at_end;
    logic [16:0] offs;
    logic [3:0]  shamt;
    logic [11:0] off_mask;
    logic [31:0] tsec;
    logic [23:0] span;
    logic [31:0] dsec;

    always_comb begin
        if (!item.mode) begin
            c = item.start_cluster;
        end else if (geom.fat16) begin
            c = item.table_word;
        end else if ((state.cluster & ODD_BIT) != 16'd0) begin
            c = item.table_word >> 4;
        end else begin
            c = item.table_word & FAT12_MASK;
        end

        at_end = geom.fat16 ? (c >= FAT16_END) : (c >= FAT12_END);

        // FAT12 entries are 1.5 bytes, FAT16 entries 2 bytes
        offs     = geom.fat16 ? {c, 1'b0} : (17'(c) + 17'(c[15:1]));
        shamt    = SHIFT_MIN + 4'(geom.shift_sel);
        off_mask = (12'd1 << shamt) - 12'd1;
        tsec     = geom.first_table + 32'(offs >> shamt);
        span     = 24'(c) * 24'(geom.cluster_sectors);
        dsec     = geom.data_base + 32'(span);

        res.cluster_now = c;
        res.chain_end   = at_end;
        state_next.cluster = c;
        if (at_end) begin
            res.table_sector  = 32'd0;
            res.entry_offset  = 12'd0;
            res.data_sector   = 32'd0;
            res.reload_table  = 1'b0;
            state_next.prev_sector = state.prev_sector;
            state_next.last_valid  = item.mode && state.last_valid;
        end else begin
            res.table_sector  = tsec;
            res.entry_offset  = offs[11:0] & off_mask;
            res.data_sector   = dsec;
            res.reload_table  = !(item.mode && state.last_valid)
                                || (state.prev_sector != tsec);
            state_next.prev_sector = tsec;
            state_next.last_valid  = 1'b1;
        end
    end

endmodule

// File: rtl/fat_cluster_chain_addresser.sv
// Top level of the FAT12/FAT16 cluster chain addresser.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    mode, start_cluster, table_word
//   m_       out        m_valid / m_ready    cluster, end flag, sectors, offset, reload
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat per cycle sustained while m_ready is high and the geometry is settled; a beat's result
// is loaded via the input register, then link logic into the result register.
// The walk state updates when a beat moves into the result register, so back-to-back
// links chain through it with no bubble.
// After reset and after each register write, s_ready stays low while the derived volume
// geometry settles. A stalled m_ side holds both stages.
module fat_cluster_chain_addresser (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [15:0]                   s_start_cluster,
    input  logic [15:0]                   s_table_word,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_cluster_now,
    output logic                          m_chain_end,
    output logic [31:0]                   m_table_sector,
    output logic [11:0]                   m_entry_offset,
    output logic [31:0]                   m_data_sector,
    output logic                          m_reload_table,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import fca_pkg::*;

    geom_t       geom;
    logic        cfg_busy;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_res_reg;

    walk_state_t walk_reg;
    walk_state_t walk_next;
    result_t     step_res;
    item_t       s_item;

    logic        advance;

    fca_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .busy      (cfg_busy)
    );

    fca_step u_step (
        .geom       (geom),
        .item       (in_item_reg),
        .state      (walk_reg),
        .res        (step_res),
        .state_next (walk_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !cfg_busy && (!in_valid_reg || advance);

    always_comb begin
        s_item.mode          = s_mode;
        s_item.start_cluster = s_start_cluster;
        s_item.table_word    = s_table_word;
    end

    always_comb begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            walk_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                walk_reg <= walk_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_cluster_now  = out_res_reg.cluster_now;
    assign m_chain_end    = out_res_reg.chain_end;
    assign m_table_sector = out_res_reg.table_sector;
    assign m_entry_offset = out_res_reg.entry_offset;
    assign m_data_sector  = out_res_reg.data_sector;
    assign m_reload_table = out_res_reg.reload_table;

    // an ended chain carries no addresses
    a_end_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chain_end |->
            m_table_sector == 32'd0 && m_data_sector == 32'd0 && !m_reload_table)
        else $error("ended chain result carries addresses");

    // a live link leaves its table sector as the last one read
    a_last_sector : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !step_res.chain_end |=>
            walk_reg.last_valid && walk_reg.prev_sector == m_table_sector)
        else $error("last table sector not tracked");

    a_adv_out : assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced beat lost");

    // smallest sector keeps the offset below 512
    a_offset_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && geom.shift_sel == 2'd0 |-> m_entry_offset[11:9] == 3'd0)
        else $error("entry offset beyond sector");

endmodule
